// ===== rtl/core/lrpg_pkg.sv =====
// shared types and constants for the lcg random pixel generator
package lrpg_pkg;

   // field and state widths
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned STATE_W = 48;
   localparam int unsigned DRAW_W  = 32;
   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned COUNT_W = 6;

   // pixel modes; the fourth code behaves as full color
   localparam logic [MODE_W-1:0] MODE_COLOR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GRAY  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MONO  = 2'd2;

   // generator constants: multiplier split as HI * 2^32 + LO
   localparam logic [31:0]        LCG_MUL_LO = 32'hDEEC_E66D;
   localparam logic [2:0]         LCG_MUL_HI = 3'd5;
   localparam logic [STATE_W-1:0] LCG_ADD    = 48'h0000_0000_000B;

   // pixels per draw in the packed modes
   localparam logic [COUNT_W-1:0] GRAY_PER_DRAW = 6'd4;
   localparam logic [COUNT_W-1:0] MONO_PER_DRAW = 6'd32;

   // pixel words
   localparam logic [PIXEL_W-1:0] PIXEL_ALPHA = 32'hFF00_0000;
   localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 32'hFFFF_FFFF;

   // one request item held in the input register
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              frame_start;
   } req_item_type;

endpackage

// ===== rtl/core/lcg_random_pixel_generator_top.sv =====
// top level of the lcg random pixel generator
//
//   channel   ports                          direction
//   req       req_valid/req_ready, fields    in   mode, frame_start
//   rsp       rsp_valid/rsp_ready, fields    out  pixel
//   csr       csr_we, csr_wdata              in   seed (loads generator)
//
// one pixel per cycle sustained while rsp_ready is high; an accepted item passes
// the input register, then the result register, before the result is valid.
// the generator advance (one 32x32 multiply plus narrow terms) sets the cycle time.
// synchronous reset clears the generator, the leftover bits and both valid flags.
// a stalled result holds its register; the input register fills behind it.
module lcg_random_pixel_generator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lrpg_pkg::MODE_W-1:0]   req_mode,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lrpg_pkg::PIXEL_W-1:0]  rsp_pixel,
   input  logic                          csr_we,
   input  logic [lrpg_pkg::STATE_W-1:0]  csr_wdata
);

   logic                   item_valid;
   logic                   item_take;
   lrpg_pkg::req_item_type item;

   // input register
   lrpg_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_frame_start (req_frame_start),
      .item_valid      (item_valid),
      .item            (item),
      .item_take       (item_take)
   );

   // generator and result register
   lrpg_pixel_unit u_pixel_unit (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_pixel  (rsp_pixel)
   );

endmodule

// ===== rtl/core/lrpg_lcg_step.sv =====
// one advance of the 48-bit linear congruential generator
module lrpg_lcg_step (
   input  logic [lrpg_pkg::STATE_W-1:0] state,
   output logic [lrpg_pkg::STATE_W-1:0] state_next
);

   logic [lrpg_pkg::STATE_W-1:0] prod_lo;
   logic [15:0] prod_hi;
   logic [15:0] prod_x5;
   logic [lrpg_pkg::STATE_W-1:0] upper_sum;

   // state * mul mod 2^48: one 32x32 product plus two narrow ones landing at bit 32
   assign prod_lo = 48'(state[31:0]) * 48'(lrpg_pkg::LCG_MUL_LO);
   assign prod_hi = state[47:32] * lrpg_pkg::LCG_MUL_LO[15:0];
   assign prod_x5 = state[15:0] * 16'(lrpg_pkg::LCG_MUL_HI);

   assign upper_sum = {prod_hi + prod_x5, 32'h0};

   assign state_next = prod_lo + upper_sum + lrpg_pkg::LCG_ADD;

endmodule

// ===== rtl/core/lrpg_in_stage.sv =====
// input register for request items
module lrpg_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [lrpg_pkg::MODE_W-1:0] req_mode,
   input  logic                       req_frame_start,
   output logic                       item_valid,
   output lrpg_pkg::req_item_type     item,
   input  logic                       item_take
);

   logic                   valid_ff;
   logic                   valid_in;
   lrpg_pkg::req_item_type item_ff;

   // free when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || item_take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !item_take);

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.mode        <= req_mode;
         item_ff.frame_start <= req_frame_start;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/lrpg_pixel_unit.sv =====
// generator state, leftover draw bits and the result register
module lrpg_pixel_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  lrpg_pkg::req_item_type        item,
   output logic                          item_take,
   input  logic                          csr_we,
   input  logic [lrpg_pkg::STATE_W-1:0]  csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lrpg_pkg::PIXEL_W-1:0]  rsp_pixel
);

   logic [lrpg_pkg::STATE_W-1:0] state_ff, state_in, state_next;
   logic [lrpg_pkg::DRAW_W-1:0]  bits_ff, bits_in;
   logic [lrpg_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [lrpg_pkg::MODE_W-1:0]  prev_mode_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lrpg_pkg::PIXEL_W-1:0] pixel_ff, pixel_in;

   logic                         discard;
   logic [lrpg_pkg::DRAW_W-1:0]  bits_cur, bits_use;
   logic [lrpg_pkg::COUNT_W-1:0] count_cur;
   logic [lrpg_pkg::DRAW_W-1:0]  draw_val;
   logic                         need_draw;
   logic [7:0]                   grey;

   lrpg_lcg_step u_step (
      .state      (state_ff),
      .state_next (state_next)
   );

   assign draw_val = state_next[47:16];

   // move the held item when the result register is free or being emptied
   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);

   // frame start or mode change drops what is left of the last draw
   assign discard   = item.frame_start || (item.mode != prev_mode_ff);
   assign bits_cur  = discard ? '0 : bits_ff;
   assign count_cur = discard ? '0 : count_ff;
   assign need_draw = (count_cur == '0);
   assign bits_use  = need_draw ? draw_val : bits_cur;
   assign grey      = bits_use[7:0];

   // pixel and next leftover state per mode
   always_comb begin
      pixel_in = lrpg_pkg::PIXEL_ALPHA;
      bits_in  = '0;
      count_in = '0;
      state_in = state_next;
      case (item.mode)
         lrpg_pkg::MODE_GRAY: begin
            pixel_in = lrpg_pkg::PIXEL_ALPHA | {8'h00, grey, grey, grey};
            bits_in  = bits_use >> 8;
            count_in = (need_draw ? lrpg_pkg::GRAY_PER_DRAW : count_cur) - 6'd1;
            state_in = need_draw ? state_next : state_ff;
         end
         lrpg_pkg::MODE_MONO: begin
            pixel_in = bits_use[0] ? lrpg_pkg::PIXEL_WHITE : lrpg_pkg::PIXEL_ALPHA;
            bits_in  = bits_use >> 1;
            count_in = (need_draw ? lrpg_pkg::MONO_PER_DRAW : count_cur) - 6'd1;
            state_in = need_draw ? state_next : state_ff;
         end
         default: begin
            pixel_in = lrpg_pkg::PIXEL_ALPHA | draw_val;
            bits_in  = '0;
            count_in = '0;
            state_in = state_next;
         end
      endcase
   end

   assign rsp_valid_in = item_take || (rsp_valid_ff && !rsp_ready);

   // control and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         bits_ff      <= '0;
         count_ff     <= '0;
         prev_mode_ff <= lrpg_pkg::MODE_COLOR;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            state_ff <= csr_wdata;
         end else if (item_take) begin
            state_ff <= state_in;
         end
         if (item_take) begin
            bits_ff      <= bits_in;
            count_ff     <= count_in;
            prev_mode_ff <= item.mode;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (item_take) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = pixel_ff;

`ifndef SYNTHESIS
   // leftover count never exceeds one draw of mono pixels
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lrpg_pkg::MONO_PER_DRAW)
      else $error("leftover count out of range");

   // a full color item leaves nothing over
   a_color_clears: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.mode == lrpg_pkg::MODE_COLOR) |=> (count_ff == '0 && bits_ff == '0))
      else $error("leftover bits kept after full color item");

   // a grey item leaves at most three bytes
   a_gray_count: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.mode == lrpg_pkg::MODE_GRAY) |=> (count_ff < lrpg_pkg::GRAY_PER_DRAW))
      else $error("grey leftover count too large");

   // the generator only moves on an item or a seed write
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!item_take && !csr_we) |=> $stable(state_ff))
      else $error("generator state moved without cause");
`endif

endmodule
